FILE: hdl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Control word layout, step addresses and microprogram of the process
// identifier allocator, plus result status codes.
// ----------------------------------------------------------------------------
package pida_pkg;

    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_DISP,
        OP_RD,
        OP_RCMP,
        OP_RNXT,
        OP_RELOK,
        OP_RELMISS,
        OP_OUT,
        OP_ACHK,
        OP_ACAND,
        OP_FFREE,
        OP_FSTEP,
        OP_NLINIT,
        OP_NL,
        OP_SLOT,
        OP_AOK,
        OP_AFULL
    } t_op;

    typedef logic [4:0] t_pc;

    localparam t_pc PC_IDLE   = 5'd0;
    localparam t_pc PC_DISP   = 5'd1;
    localparam t_pc PC_RRD    = 5'd2;
    localparam t_pc PC_RCMP   = 5'd3;
    localparam t_pc PC_RNXT   = 5'd4;
    localparam t_pc PC_RDONE  = 5'd5;
    localparam t_pc PC_RMISS  = 5'd6;
    localparam t_pc PC_OUT    = 5'd7;
    localparam t_pc PC_ACHK   = 5'd8;
    localparam t_pc PC_ACAND  = 5'd9;
    localparam t_pc PC_SCAN   = 5'd10;
    localparam t_pc PC_FSTEP  = 5'd11;
    localparam t_pc PC_NLINIT = 5'd12;
    localparam t_pc PC_NL     = 5'd13;
    localparam t_pc PC_SLOT   = 5'd14;
    localparam t_pc PC_AOK    = 5'd15;
    localparam t_pc PC_AFULL  = 5'd16;

    typedef struct packed {
        t_op op;
        t_pc jmp_t;
        t_pc jmp_f;
    } t_ctrl;

    function automatic t_ctrl ctrl_rom(input t_pc pc);
        t_ctrl w;
        unique case (pc)
            PC_IDLE:   w = '{OP_IDLE,    PC_DISP,   PC_IDLE};
            PC_DISP:   w = '{OP_DISP,    PC_RRD,    PC_ACHK};
            PC_RRD:    w = '{OP_RD,      PC_RCMP,   PC_RCMP};
            PC_RCMP:   w = '{OP_RCMP,    PC_RDONE,  PC_RNXT};
            PC_RNXT:   w = '{OP_RNXT,    PC_RMISS,  PC_RRD};
            PC_RDONE:  w = '{OP_RELOK,   PC_OUT,    PC_OUT};
            PC_RMISS:  w = '{OP_RELMISS, PC_OUT,    PC_OUT};
            PC_OUT:    w = '{OP_OUT,     PC_IDLE,   PC_OUT};
            PC_ACHK:   w = '{OP_ACHK,    PC_AFULL,  PC_ACAND};
            PC_ACAND:  w = '{OP_ACAND,   PC_SCAN,   PC_SLOT};
            PC_SCAN:   w = '{OP_FFREE,   PC_NLINIT, PC_FSTEP};
            PC_FSTEP:  w = '{OP_FSTEP,   PC_AFULL,  PC_SCAN};
            PC_NLINIT: w = '{OP_NLINIT,  PC_NL,     PC_NL};
            PC_NL:     w = '{OP_NL,      PC_SLOT,   PC_NL};
            PC_SLOT:   w = '{OP_SLOT,    PC_AOK,    PC_SLOT};
            PC_AOK:    w = '{OP_AOK,     PC_OUT,    PC_OUT};
            PC_AFULL:  w = '{OP_AFULL,   PC_OUT,    PC_OUT};
            default:   w = '{OP_IDLE,    PC_IDLE,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/process_id_allocator.sv
// ----------------------------------------------------------------------------
// process_id_allocator
// Hands out and releases unique process identifiers, 1 to PID_LIMIT-1, from a
// table of TABLE_DEPTH live slots, driven by a microcoded step sequencer.
// ----------------------------------------------------------------------------
// One request word is taken at a time; o_stall is low only while the
// sequencer waits for a request. A release reads and compares one table slot
// at a time, in read, compare and next steps, and loads its result once a
// slot matches or the last slot is passed. An allocation below the safe bound
// walks the slot valid bits, one per cycle; one at or past the bound first
// runs the free search, testing one identifier and stepping to the next
// (at most two passes over the identifier space, and no more than
// TABLE_DEPTH identifiers while fewer than PID_LIMIT-1 are live), then
// walks to the next live bound one identifier per cycle, stopping at
// PID_LIMIT, before the slot walk. The rate is set by the sequencer, which
// runs one control word per cycle and visits slots and identifiers one at a
// time; slot contents come through the single table read port. The result
// sits in an output register, so the next request is taken while it waits.
module process_id_allocator #(
    parameter int TABLE_DEPTH = 64,
    parameter int PID_LIMIT   = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_req_type,
    input  logic [6:0] i_release_pid,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_result_pid,
    output logic [1:0] o_status
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = $clog2(PID_LIMIT);
    localparam int BW = $clog2(PID_LIMIT + 1);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (PW > 7) ? PW : 7;

    pida_pkg::t_pc   r_pc;
    pida_pkg::t_ctrl w_ctrl;
    logic            w_cond;

    logic                   r_req;
    logic [6:0]             r_rel;
    logic [IW-1:0]          r_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [PID_LIMIT-1:0]   r_occ;
    logic [PW-1:0]          r_mem [TABLE_DEPTH];
    logic [PW-1:0]          r_rdata;
    logic [BW-1:0]          r_last;
    logic [BW-1:0]          r_safe;
    logic [NW-1:0]          r_count;
    logic [PW-1:0]          r_p;
    logic [BW-1:0]          r_q;
    logic                   r_second;
    logic [6:0]             r_res_pid;
    logic [1:0]             r_res_status;
    logic                   r_o_valid;
    logic [6:0]             r_o_pid;
    logic [1:0]             r_o_status;

    logic          w_in_accept;
    logic          w_out_free;
    logic [BW:0]   w_cand;
    logic          w_wrap;
    logic          w_need_scan;
    logic [PW-1:0] w_cand_p;
    logic          w_full;
    logic          w_p_last;
    logic          w_q_end;
    logic          w_hit;
    logic          w_idx_last;
    logic [CW-1:0] w_p_ext;
    logic          w_mem_we;

    assign w_ctrl      = pida_pkg::ctrl_rom(r_pc);
    assign o_stall     = (r_pc != pida_pkg::PC_IDLE);
    assign w_in_accept = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;

    assign w_cand      = {1'b0, r_last} + (BW+1)'(1);
    assign w_wrap      = w_cand >= (BW+1)'(PID_LIMIT);
    assign w_need_scan = w_wrap || (w_cand >= {1'b0, r_safe});
    assign w_cand_p    = w_wrap ? PW'(1) : w_cand[PW-1:0];
    assign w_full      = r_count >= NW'(TABLE_DEPTH);
    assign w_p_last    = r_p == PW'(PID_LIMIT - 1);
    assign w_q_end     = r_q == BW'(PID_LIMIT);
    assign w_hit       = r_valid[r_idx] && (CW'(r_rdata) == CW'(r_rel));
    assign w_idx_last  = r_idx == IW'(TABLE_DEPTH - 1);
    assign w_p_ext     = CW'(r_p);
    assign w_mem_we    = (w_ctrl.op == pida_pkg::OP_AOK);

    always_comb begin
        unique case (w_ctrl.op)
            pida_pkg::OP_IDLE:    w_cond = w_in_accept;
            pida_pkg::OP_DISP:    w_cond = r_req;
            pida_pkg::OP_RCMP:    w_cond = w_hit;
            pida_pkg::OP_RNXT:    w_cond = w_idx_last;
            pida_pkg::OP_OUT:     w_cond = w_out_free;
            pida_pkg::OP_ACHK:    w_cond = w_full;
            pida_pkg::OP_ACAND:   w_cond = w_need_scan;
            pida_pkg::OP_FFREE:   w_cond = !r_occ[r_p];
            pida_pkg::OP_FSTEP:   w_cond = w_p_last && r_second;
            pida_pkg::OP_NL:      w_cond = w_q_end || r_occ[r_q[PW-1:0]];
            pida_pkg::OP_SLOT:    w_cond = !r_valid[r_idx];
            default:              w_cond = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= r_p;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= pida_pkg::PC_IDLE;
            r_valid   <= '0;
            r_occ     <= '0;
            r_last    <= BW'(PID_LIMIT);
            r_safe    <= BW'(PID_LIMIT);
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_pc <= w_cond ? w_ctrl.jmp_t : w_ctrl.jmp_f;
            if ((w_ctrl.op == pida_pkg::OP_OUT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (w_ctrl.op)
                pida_pkg::OP_IDLE: begin
                    if (w_in_accept) begin
                        r_req <= i_req_type;
                        r_rel <= i_release_pid;
                    end
                end
                pida_pkg::OP_DISP: begin
                    r_idx <= '0;
                end
                pida_pkg::OP_RNXT: begin
                    if (!w_idx_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                pida_pkg::OP_RELOK: begin
                    r_valid[r_idx] <= 1'b0;
                    r_occ[r_rdata] <= 1'b0;
                    r_count        <= r_count - NW'(1);
                    r_res_pid      <= r_rel;
                    r_res_status   <= pida_pkg::ST_RELEASED;
                end
                pida_pkg::OP_RELMISS: begin
                    r_res_pid    <= '0;
                    r_res_status <= pida_pkg::ST_MISSING;
                end
                pida_pkg::OP_OUT: begin
                    if (w_out_free) begin
                        r_o_pid    <= r_res_pid;
                        r_o_status <= r_res_status;
                    end
                end
                pida_pkg::OP_ACAND: begin
                    r_p      <= w_cand_p;
                    r_second <= (w_cand_p == PW'(1));
                end
                pida_pkg::OP_FSTEP: begin
                    if (w_p_last) begin
                        r_p      <= PW'(1);
                        r_second <= 1'b1;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                pida_pkg::OP_NLINIT: begin
                    r_q <= BW'(r_p) + BW'(1);
                end
                pida_pkg::OP_NL: begin
                    if (w_cond) begin
                        r_safe <= r_q;
                    end else begin
                        r_q <= r_q + BW'(1);
                    end
                end
                pida_pkg::OP_SLOT: begin
                    if (!w_cond) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                pida_pkg::OP_AOK: begin
                    r_valid[r_idx] <= 1'b1;
                    r_occ[r_p]     <= 1'b1;
                    r_count        <= r_count + NW'(1);
                    r_last         <= BW'(r_p);
                    r_res_pid      <= w_p_ext[6:0];
                    r_res_status   <= pida_pkg::ST_ALLOC;
                end
                pida_pkg::OP_AFULL: begin
                    r_res_pid    <= '0;
                    r_res_status <= pida_pkg::ST_FULL;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_result_pid = r_o_pid;
    assign o_status     = r_o_status;

    a_count_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'($countones(r_valid)) == r_count)
        else $error("live count out of step with slot valid bits");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(TABLE_DEPTH))
        else $error("live count above table depth");

    a_bound_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == pida_pkg::OP_IDLE) |->
        ((r_last < r_safe) || (r_last == BW'(PID_LIMIT))))
        else $error("safe bound not above last identifier");

    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == pida_pkg::OP_AOK) |=> r_occ[$past(r_p)])
        else $error("allocated identifier not marked live");

endmodule
